### rtl/hbr_pkg.sv
package hbr_pkg;

    localparam int TEXT_W  = 8;
    localparam int NUM_W   = 64;
    localparam int ACC_W   = NUM_W + 4;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 2 * NUM_W;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    localparam logic [TEXT_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [TEXT_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [TEXT_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic             failed;
        logic             prefix_done;
        logic             after_dash;
        logic             first_has_digit;
        logic             second_has_digit;
        logic [NUM_W-1:0] first_number;
        logic [NUM_W-1:0] second_number;
        logic [NUM_W-1:0] total_length;
    } hbr_snap_t;

    // expected character of "bytes=" at each prefix position
    function automatic logic [TEXT_W-1:0] hbr_prefix_char(input logic [2:0] pos);
        logic [TEXT_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### rtl/hbr_parse.sv
module hbr_parse (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // text_byte [7:0], total_length [71:8]
    input  logic [hbr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              snap_ready,
    output logic                              snap_valid,
    output hbr_pkg::hbr_snap_t                snap
);
    import hbr_pkg::*;

    logic                in_valid_reg;
    logic [TEXT_W-1:0]   in_byte_reg;
    logic                in_last_reg;
    logic [NUM_W-1:0]    in_total_reg;

    logic [2:0]          pos_reg, pos_next;
    logic                after_dash_reg, after_dash_next;
    logic [NUM_W-1:0]    first_reg, first_next;
    logic                first_has_reg, first_has_next;
    logic [NUM_W-1:0]    second_reg, second_next;
    logic                second_has_reg, second_has_next;
    logic                failed_reg, failed_next;

    hbr_snap_t           snap_reg, snap_next;
    logic                snap_valid_reg, snap_valid_next;

    logic                take;
    logic [NUM_W-1:0]    acc_sel;
    logic [ACC_W-1:0]    acc_wide;
    logic [TEXT_W-1:0]   digit_val;

    assign take          = in_valid_reg && (!in_last_reg || !snap_valid_reg || snap_ready);
    assign s_axis_tready = !in_valid_reg || take;
    assign snap_valid    = snap_valid_reg;
    assign snap          = snap_reg;

    // multiply-by-ten accumulate on the active part
    assign acc_sel   = after_dash_reg ? second_reg : first_reg;
    assign digit_val = in_byte_reg - CHAR_ZERO;
    assign acc_wide  = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
                     + {{(ACC_W-4){1'b0}}, digit_val[3:0]};

    always_comb
    begin
        pos_next        = pos_reg;
        after_dash_next = after_dash_reg;
        first_next      = first_reg;
        first_has_next  = first_has_reg;
        second_next     = second_reg;
        second_has_next = second_has_reg;
        failed_next     = failed_reg;
        if (in_byte_reg == CHAR_COMMA)
        begin
            failed_next = 1'b1;
        end
        else if (pos_reg < PREFIX_LEN)
        begin
            if (in_byte_reg != hbr_prefix_char(pos_reg))
            begin
                failed_next = 1'b1;
            end
            pos_next = pos_reg + 3'd1;
        end
        else if (in_byte_reg == CHAR_DASH && !after_dash_reg)
        begin
            after_dash_next = 1'b1;
        end
        else if (!(in_byte_reg inside {[CHAR_ZERO:CHAR_NINE]}))
        begin
            failed_next = 1'b1;
        end
        else
        begin
            if (acc_wide[ACC_W-1:NUM_W] != 4'd0)
            begin
                failed_next = 1'b1;
            end
            else if (after_dash_reg)
            begin
                second_next = acc_wide[NUM_W-1:0];
            end
            else
            begin
                first_next = acc_wide[NUM_W-1:0];
            end
            if (after_dash_reg)
            begin
                second_has_next = 1'b1;
            end
            else
            begin
                first_has_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        snap_next.failed           = failed_next;
        snap_next.prefix_done      = (pos_next >= PREFIX_LEN);
        snap_next.after_dash       = after_dash_next;
        snap_next.first_has_digit  = first_has_next;
        snap_next.second_has_digit = second_has_next;
        snap_next.first_number     = first_next;
        snap_next.second_number    = second_next;
        snap_next.total_length     = in_total_reg;
        snap_valid_next = (snap_valid_reg && !snap_ready) || (take && in_last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            pos_reg        <= 3'd0;
            after_dash_reg <= 1'b0;
            first_reg      <= '0;
            first_has_reg  <= 1'b0;
            second_reg     <= '0;
            second_has_reg <= 1'b0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (take)
            begin
                if (in_last_reg)
                begin
                    // end of header: clear for the next one
                    pos_reg        <= 3'd0;
                    after_dash_reg <= 1'b0;
                    first_reg      <= '0;
                    first_has_reg  <= 1'b0;
                    second_reg     <= '0;
                    second_has_reg <= 1'b0;
                    failed_reg     <= 1'b0;
                end
                else
                begin
                    pos_reg        <= pos_next;
                    after_dash_reg <= after_dash_next;
                    first_reg      <= first_next;
                    first_has_reg  <= first_has_next;
                    second_reg     <= second_next;
                    second_has_reg <= second_has_next;
                    failed_reg     <= failed_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata[TEXT_W-1:0];
            in_last_reg  <= s_axis_tlast;
            in_total_reg <= s_axis_tdata[TEXT_W+NUM_W-1:TEXT_W];
        end
        if (take && in_last_reg)
        begin
            snap_reg <= snap_next;
        end
    end

endmodule

### rtl/hbr_eval.sv
module hbr_eval (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              snap_valid,
    input  hbr_pkg::hbr_snap_t                snap,
    output logic                              snap_ready,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // range_offset [63:0], range_length [127:64]
    output logic [hbr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // range_ok [0]
    output logic                              m_axis_tuser
);
    import hbr_pkg::*;

    logic                out_valid_reg;
    logic                ok_reg, ok_next;
    logic [NUM_W-1:0]    offset_reg, offset_next;
    logic [NUM_W-1:0]    length_reg, length_next;

    logic                base_ok;
    logic                first_in;
    logic [NUM_W-1:0]    total_minus_second;
    logic [NUM_W-1:0]    total_minus_first;
    logic [NUM_W-1:0]    span;

    assign snap_ready    = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = ok_reg;
    assign m_axis_tdata  = {length_reg, offset_reg};

    assign base_ok            = !snap.failed && snap.prefix_done && snap.after_dash;
    assign first_in           = snap.first_number < snap.total_length;
    assign total_minus_second = snap.total_length - snap.second_number;
    assign total_minus_first  = snap.total_length - snap.first_number;
    assign span               = snap.second_number - snap.first_number + 64'd1;

    always_comb
    begin
        ok_next     = 1'b0;
        offset_next = '0;
        length_next = '0;
        if (base_ok)
        begin
            if (!snap.first_has_digit)
            begin
                if (snap.second_has_digit)
                begin
                    ok_next = 1'b1;
                    if (snap.second_number <= snap.total_length)
                    begin
                        offset_next = total_minus_second;
                        length_next = snap.second_number;
                    end
                    else
                    begin
                        length_next = snap.total_length;
                    end
                end
            end
            else if (first_in)
            begin
                if (!snap.second_has_digit)
                begin
                    ok_next     = 1'b1;
                    offset_next = snap.first_number;
                    length_next = total_minus_first;
                end
                else if (snap.second_number < snap.total_length
                         && snap.second_number >= snap.first_number)
                begin
                    ok_next     = 1'b1;
                    offset_next = snap.first_number;
                    length_next = span;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            out_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            ok_reg     <= ok_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
        end
    end

endmodule

### rtl/http_byte_range_parser.sv
// channel   dir  handshake              tdata                              tuser / tlast
// s_axis    in   s_axis_tvalid/tready   text_byte[7:0], total_length[71:8] tlast = last_byte
// m_axis    out  m_axis_tvalid/tready   range_offset[63:0], range_length   tuser = range_ok
//
// One item per cycle if no output stall; limited by the 64-bit multiply-by-ten accumulate.
// A last byte passes the input, snapshot and output registers; other bytes give no result.
// Reset clears the parse state and all valid flags; no clearing pass follows.
// A stalled output holds its result while earlier stages keep filling.
module http_byte_range_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // text_byte [7:0], total_length [71:8]
    input  logic [hbr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // range_offset [63:0], range_length [127:64]
    output logic [hbr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // range_ok [0]
    output logic                              m_axis_tuser
);
    import hbr_pkg::*;

    logic      snap_valid;
    logic      snap_ready;
    hbr_snap_t snap;

    hbr_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .snap_ready    (snap_ready),
        .snap_valid    (snap_valid),
        .snap          (snap)
    );

    hbr_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_valid    (snap_valid),
        .snap          (snap),
        .snap_ready    (snap_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
